@@ rtl/core/pti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_pkg
// Shared constants, field layout and helpers for the breakpoint interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

  // table geometry
  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CountW     = $clog2(TableDepth + 1);

  // field widths
  localparam int unsigned CfgW   = 9;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StepW  = $clog2(DataW);

  // stream tdata layout (low bit first): entry_index, x_value, y_value, linear_mode
  localparam int unsigned InBits    = IdxW + DataW + DataW + 1;
  localparam int unsigned InTdataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned IdxLsb    = 0;
  localparam int unsigned XLsb      = IdxLsb + IdxW;
  localparam int unsigned YLsb      = XLsb + DataW;
  localparam int unsigned LinBit    = YLsb + DataW;

  // result layout (low bit first): result_value, status
  localparam int unsigned OutBits   = DataW + 1;
  localparam int unsigned OutTdataW = ((OutBits + 7) / 8) * 8;

  // codes
  localparam logic FuncLoad    = 1'b0;
  localparam logic FuncQuery   = 1'b1;
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  // clamp a 34-bit signed sum into the 32-bit signed range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+1:0] v);
    logic signed [DataW+1:0] hi;
    logic signed [DataW+1:0] lo;
    hi = {3'b000, {(DataW-1){1'b1}}};
    lo = {3'b111, {(DataW-1){1'b0}}};
    if (v > hi) begin
      sat32 = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

@@ rtl/core/piecewise_table_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_table_interpolator
// Breakpoint table (x, y in signed Q16.16) with linear or step interpolation.
//
// Load: goes straight to the output step, which registers the result once the
//   output register is free. Query: StLo and StHi check x[0] and x[n-1], then
//   StScan finds segment k (first entry whose x exceeds the query), one table
//   entry per cycle on the x memory read port; StFetch and StFetch2 fetch the
//   segment, then StOut in step mode, or in linear mode one multiply, 32 restoring
//   divide steps and one add, then StOut. Out-of-range lookups leave from StIdle, StLo or StHi.
// One item at a time: the input is ready again the cycle after the result is
//   registered, and the sequencer waits while the output register is still full.
// rst_ni clears control and entries_in_use; table memories are not cleared.
// ----------------------------------------------------------------------------
module piecewise_table_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // configuration: entries_in_use
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pti_pkg::CfgW-1:0]      cfg_data_i,

  // input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: entry_index[7:0], x_value[39:8], y_value[71:40], linear_mode[72], zero pad
  input  logic [pti_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // tuser: func (0 load, 1 query)
  input  logic                          s_axis_tuser_i,

  // results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: result_value[31:0], status[32], zero pad
  output logic [pti_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import pti_pkg::*;

  // sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StLo     = 4'd1;  // x[0] on read data
  localparam logic [3:0] StHi     = 4'd2;  // x[n-1] on read data
  localparam logic [3:0] StScan   = 4'd3;  // x[idx] on read data
  localparam logic [3:0] StFetch  = 4'd4;  // x0 and y1 on read data
  localparam logic [3:0] StFetch2 = 4'd5;  // y0 on read data
  localparam logic [3:0] StMul    = 4'd6;
  localparam logic [3:0] StDiv    = 4'd7;
  localparam logic [3:0] StFin    = 4'd8;
  localparam logic [3:0] StOut    = 4'd9;

  // input unpacking
  logic [IdxW-1:0]         in_idx;
  logic signed [DataW-1:0] in_x;
  logic signed [DataW-1:0] in_y;
  logic                    in_lin;
  logic                    in_fire;

  assign in_idx  = s_axis_tdata_i[IdxLsb +: IdxW];
  assign in_x    = s_axis_tdata_i[XLsb +: DataW];
  assign in_y    = s_axis_tdata_i[YLsb +: DataW];
  assign in_lin  = s_axis_tdata_i[LinBit];
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  // control state
  logic [3:0]        state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [CfgW-1:0]   cfg_q;
  logic              m_valid_q, m_valid_d;

  // payload
  logic signed [DataW-1:0] x_q, x0_q, x1_q, y0_q, y1_q, res_q;
  logic                    lin_q, stat_q, neg_q;
  logic [CountW-1:0]       n_q;
  logic [DataW-1:0]        magdy_q, num_q, den_q, rem_q, quo_q;
  logic [OutBits-1:0]      m_data_q;

  // table memories
  logic [DataW-1:0]        mem_x [TableDepth];
  logic [DataW-1:0]        mem_y [TableDepth];
  logic signed [DataW-1:0] xr_q, yr_q;
  logic [AddrW-1:0]        x_raddr, y_raddr;
  logic                    wr_en;

  // effective entry count: min(entries_in_use, depth)
  logic [CountW-1:0] n_cfg;
  assign n_cfg = (32'(cfg_q) > TableDepth) ? CountW'(TableDepth) : CountW'(cfg_q);

  assign wr_en = in_fire && (s_axis_tuser_i == FuncLoad) && (32'(in_idx) < TableDepth);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[AddrW'(in_idx)] <= in_x;
      mem_y[AddrW'(in_idx)] <= in_y;
    end
    xr_q <= mem_x[x_raddr];
    yr_q <= mem_y[y_raddr];
  end

  // segment arithmetic, evaluated in StFetch2 (y0 arrives on yr_q)
  logic signed [DataW:0]   dy_w, num_w, den_w;
  logic [DataW:0]          dy_neg;
  logic [DataW-1:0]        magdy_w;
  logic signed [DataW+1:0] x2_w, xsum_w, d_w;
  logic signed [DataW:0]   ysum_w;
  logic signed [DataW-1:0] flat_w;

  assign dy_w    = {y1_q[DataW-1], y1_q} - {yr_q[DataW-1], yr_q};
  assign dy_neg  = -dy_w;
  assign magdy_w = dy_w[DataW] ? dy_neg[DataW-1:0] : dy_w[DataW-1:0];
  assign num_w   = {x_q[DataW-1], x_q} - {x0_q[DataW-1], x0_q};
  assign den_w   = {x1_q[DataW-1], x1_q} - {x0_q[DataW-1], x0_q};

  // step mode: sign of 2x - (x0 + x1); tie gives floor of the y average
  assign x2_w   = {x_q[DataW-1], x_q, 1'b0};
  assign xsum_w = {{2{x0_q[DataW-1]}}, x0_q} + {{2{x1_q[DataW-1]}}, x1_q};
  assign d_w    = x2_w - xsum_w;
  assign ysum_w = {yr_q[DataW-1], yr_q} + {y1_q[DataW-1], y1_q};
  assign flat_w = (d_w > 0) ? y1_q : ((d_w < 0) ? yr_q : ysum_w[DataW:1]);

  // restoring divide step; remainder always stays below den_q
  logic [DataW:0]   trial_w, diff_w;
  logic             qbit_w;
  assign trial_w = {rem_q, quo_q[DataW-1]};
  assign diff_w  = trial_w - {1'b0, den_q};
  assign qbit_w  = (trial_w >= {1'b0, den_q});

  logic [2*DataW-1:0] prod_w;
  assign prod_w = magdy_q * num_q;

  // final add: y0 +/- quotient, clamped
  logic signed [DataW+1:0] y0e_w, qe_w, sum_w;
  assign y0e_w = {{2{y0_q[DataW-1]}}, y0_q};
  assign qe_w  = {2'b00, quo_q};
  assign sum_w = neg_q ? (y0e_w - qe_w) : (y0e_w + qe_w);

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    x_raddr   = idx_q;
    y_raddr   = idx_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser_i == FuncQuery && n_cfg >= CountW'(2)) begin
            x_raddr = '0;
            state_d = StLo;
          end else begin
            state_d = StOut;
          end
        end
      end
      StLo: begin
        if (!(x_q > xr_q)) begin
          state_d = StOut;
        end else begin
          x_raddr = AddrW'(n_q - CountW'(1));
          state_d = StHi;
        end
      end
      StHi: begin
        if (!(x_q < xr_q)) begin
          state_d = StOut;
        end else begin
          idx_d   = AddrW'(1);
          x_raddr = AddrW'(1);
          state_d = StScan;
        end
      end
      StScan: begin
        // x[n-1] > x is known, so the scan stops at n-1 at the latest
        if (xr_q > x_q) begin
          x_raddr = idx_q - AddrW'(1);
          y_raddr = idx_q;
          state_d = StFetch;
        end else begin
          idx_d   = idx_q + AddrW'(1);
          x_raddr = idx_q + AddrW'(1);
        end
      end
      StFetch: begin
        y_raddr = idx_q - AddrW'(1);
        state_d = StFetch2;
      end
      StFetch2: begin
        state_d = lin_q ? StMul : StOut;
      end
      StMul: begin
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == '1) begin
          state_d = StFin;
        end
      end
      StFin: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idx_q     <= '0;
      cnt_q     <= '0;
      cfg_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          x_q    <= in_x;
          lin_q  <= in_lin;
          n_q    <= n_cfg;
          res_q  <= '0;
          stat_q <= (s_axis_tuser_i == FuncQuery && n_cfg < CountW'(2)) ?
                    StatusRange : StatusOk;
        end
      end
      StLo: begin
        if (!(x_q > xr_q)) stat_q <= StatusRange;
      end
      StHi: begin
        if (!(x_q < xr_q)) stat_q <= StatusRange;
      end
      StScan: begin
        x1_q <= xr_q;
      end
      StFetch: begin
        x0_q <= xr_q;
        y1_q <= yr_q;
      end
      StFetch2: begin
        y0_q    <= yr_q;
        res_q   <= flat_w;
        magdy_q <= magdy_w;
        neg_q   <= dy_w[DataW];
        num_q   <= num_w[DataW-1:0];
        den_q   <= den_w[DataW-1:0];
      end
      StMul: begin
        rem_q <= prod_w[2*DataW-1:DataW];
        quo_q <= prod_w[DataW-1:0];
      end
      StDiv: begin
        rem_q <= qbit_w ? diff_w[DataW-1:0] : trial_w[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], qbit_w};
      end
      StFin: begin
        res_q <= sat32(sum_w);
      end
      StOut: begin
        if (out_free) m_data_q <= {stat_q, res_q};
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - OutBits){1'b0}}, m_data_q};

  // checks
  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> CountW'(idx_q) < n_q)
    else $error("scan index ran past the active entries");

  a_num_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul |-> num_q < den_q)
    else $error("segment offset not below segment width");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> rem_q < den_q)
    else $error("divider remainder out of range");

  a_fetch_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFetch |-> $past(state_q) == StScan)
    else $error("segment fetch without a completed scan");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == StOut)
    else $error("result transfer raised outside the output step");

endmodule

@@ tb/tb_piecewise_table_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_table_interpolator
// Drives breakpoint loads and lookups over the input stream. A behavioral copy
// of the table predicts each result, and every output transfer is checked
// field by field. The run covers empty, single-entry and full tables, exact
// breakpoints, exact midpoints, range edges and non-monotonic tables. It runs
// with gaps on the sender, stalls on the receiver, and one long output hold.
// ----------------------------------------------------------------------------
module tb_piecewise_table_interpolator;
  import pti_pkg::*;

  // no-transfer limit, far above a full-table lookup and the hold-off
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 60;

  localparam longint QMin = 64'shFFFF_FFFF_8000_0000;
  localparam longint QMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMinW = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] QMaxW = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    status;
  } lookup_result_t;

  // DUT ports, every input known from time zero
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i      = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // tdata: entry_index, x_value, y_value, linear_mode, zero pad
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  // tuser: func
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // tdata: result_value, status, zero pad
  logic [OutTdataW-1:0] m_axis_tdata_o;

  // predictor state: table copy and the register
  logic signed [DataW-1:0] bp_x [TableDepth];
  logic signed [DataW-1:0] bp_y [TableDepth];
  int unsigned             entries_in_use_q = 0;

  lookup_result_t pending_results[$];

  // stream pacing knobs; a hold-off is requested by bumping hold_request
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;

  // bookkeeping
  int unsigned n_errors    = 0;
  int unsigned n_checked   = 0;
  int unsigned n_loads     = 0;
  int unsigned n_queries   = 0;
  int unsigned n_range     = 0;
  int unsigned n_midpoints = 0;
  int unsigned max_entries = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  piecewise_table_interpolator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic signed [DataW-1:0] clamp_q16(input longint v);
    if (v > QMax) return QMaxW;
    if (v < QMin) return QMinW;
    return DataW'(v);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // y0 + trunc(dy * dx / span); product kept as an unsigned 64-bit magnitude
  function automatic logic signed [DataW-1:0] linear_point(input longint x, input longint x0,
      input longint x1, input longint y0, input longint y1);
    longint      dy;
    longint      dx;
    longint      span;
    logic [63:0] quot;
    logic        neg;
    dy   = y1 - y0;
    dx   = x - x0;
    span = x1 - x0;
    if (span == 0) return clamp_q16(y0);
    neg  = ((dy < 0) != (dx < 0)) != (span < 0);
    quot = magnitude(dy) * magnitude(dx) / magnitude(span);
    if (quot == 0) return clamp_q16(y0);
    if (quot > 64'h2_0000_0000) return neg ? QMinW : QMaxW;
    return clamp_q16(neg ? y0 - longint'(quot) : y0 + longint'(quot));
  endfunction

  // nearest end of the segment; exact midpoint takes the floored average
  function automatic logic signed [DataW-1:0] step_point(input longint x, input longint x0,
      input longint x1, input longint y0, input longint y1);
    longint side;
    side = 2 * x - (x0 + x1);
    if (side > 0) return clamp_q16(y1);
    if (side < 0) return clamp_q16(y0);
    n_midpoints++;
    return clamp_q16((y0 + y1) >>> 1);
  endfunction

  // applies one accepted item to the table copy and returns its result
  function automatic lookup_result_t predict_lookup(input logic func,
      input logic [IdxW-1:0] idx, input logic signed [DataW-1:0] xv,
      input logic signed [DataW-1:0] yv, input logic lin);
    lookup_result_t res;
    int unsigned    n;
    longint         x;
    res = '0;
    res.status = StatusOk;
    x = xv;
    if (func == FuncLoad) begin
      n_loads++;
      if (idx < TableDepth) begin
        bp_x[idx] = xv;
        bp_y[idx] = yv;
      end
      return res;
    end
    n_queries++;
    n = (entries_in_use_q < TableDepth) ? entries_in_use_q : TableDepth;
    if (n < 2 || x <= bp_x[0] || x >= bp_x[n-1]) begin
      res.status = StatusRange;
      n_range++;
      return res;
    end
    // first breakpoint strictly above the query point closes the segment
    for (int unsigned i = 1; i < n; i++) begin
      if (bp_x[i] > x) begin
        res.value = lin ? linear_point(x, bp_x[i-1], bp_x[i], bp_y[i-1], bp_y[i])
                        : step_point(x, bp_x[i-1], bp_x[i], bp_y[i-1], bp_y[i]);
        return res;
      end
    end
    res.status = StatusRange;
    n_range++;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stream drivers
  // --------------------------------------------------------------------------

  // Offers one item and waits for the transfer. tvalid stays high afterward;
  // the next call or drain_results() settles it in the same step.
  task automatic send_item(input logic func, input logic [IdxW-1:0] idx,
                           input logic signed [DataW-1:0] xv,
                           input logic signed [DataW-1:0] yv, input logic lin);
    logic [InTdataW-1:0] beat;
    beat = '0;
    beat[IdxLsb +: IdxW] = idx;
    beat[XLsb +: DataW]  = xv;
    beat[YLsb +: DataW]  = yv;
    beat[LinBit]         = lin;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= beat;
    s_axis_tuser_i  <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_lookup(func, idx, xv, yv, lin));
  endtask

  // Stop offering and wait for every expected result. Each item has exactly
  // one result, so an empty queue means the block is idle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_entries_in_use(input int unsigned count);
    cfg_data_i  <= CfgW'(count);
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    entries_in_use_q = count;
    if (count > max_entries) max_entries = count;
  endtask

  function automatic logic signed [DataW-1:0] random_ordinate();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? QMaxW : QMinW;
      default: return $urandom();
    endcase
  endfunction

  // Loads entries 0..n-1 with strictly increasing x: either spread over the
  // whole Q16.16 range or packed tightly around a random base.
  task automatic fill_table(input int unsigned n);
    longint pitch;
    longint xv;
    logic   wide;
    wide  = $urandom_range(1);
    pitch = 64'sh0_FFFF_FFFF / longint'((n > 0) ? n : 1);
    xv    = longint'($urandom_range(2097152)) - 1048576;
    for (int unsigned i = 0; i < n; i++) begin
      if (wide) begin
        xv = QMin + longint'(i) * pitch + longint'($urandom_range(32'(pitch / 2)));
      end else if (i > 0) begin
        xv = xv + longint'($urandom_range(2000, 1));
      end
      send_item(FuncLoad, IdxW'(i), DataW'(xv), random_ordinate(), $urandom_range(1));
    end
  endtask

  // Mostly lookups aimed at real segments; some loads, a few of which
  // scramble the active table so later lookups see a non-monotonic one.
  task automatic send_random_item();
    int unsigned      n;
    int unsigned      pick;
    int unsigned      k;
    longint           x0;
    longint           x1;
    longint           xq;
    longint           span;
    longint unsigned  r64;
    logic [IdxW-1:0]  idx;
    n    = (entries_in_use_q < TableDepth) ? entries_in_use_q : TableDepth;
    pick = $urandom_range(99);
    if (pick < 15) begin
      if (n < TableDepth && $urandom_range(3) != 0) begin
        idx = IdxW'($urandom_range(TableDepth - 1, n));
      end else begin
        idx = IdxW'($urandom_range((n > 0) ? n - 1 : TableDepth - 1));
      end
      send_item(FuncLoad, idx, $urandom(), random_ordinate(), $urandom_range(1));
      return;
    end
    if (n < 2) begin
      xq = longint'($signed($urandom()));
    end else begin
      k  = $urandom_range(n - 1, 1);
      x0 = bp_x[k-1];
      x1 = bp_x[k];
      if (pick < 60) begin
        // strictly inside the segment
        span = x1 - x0 - 1;
        r64  = {$urandom(), $urandom()};
        xq   = (span > 0) ? x0 + 1 + longint'(r64 % span) : x0;
      end else if (pick < 70) begin
        xq = (x0 + x1) >>> 1;
      end else if (pick < 80) begin
        xq = bp_x[$urandom_range(n - 1)];
      end else if (pick < 90) begin
        // one step either side of the table ends
        xq = $urandom_range(1) ? bp_x[0] : bp_x[n-1];
        xq = clamp_q16(xq + longint'($urandom_range(2)) - 1);
      end else if (pick < 95) begin
        xq = $urandom_range(1) ? QMax : QMin;
      end else begin
        xq = longint'($signed($urandom()));
      end
    end
    send_item(FuncQuery, IdxW'($urandom()), DataW'(xq), $urandom(), $urandom_range(1));
  endtask

  // --------------------------------------------------------------------------
  // Result side: receiver pacing, checker, watchdog
  // --------------------------------------------------------------------------

  // A new hold-off request takes over from random stalls and counts down here.
  always @(posedge clk_i) begin
    if (hold_request != hold_taken) begin
      hold_taken = hold_request;
      hold_left  = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] want,
                                 input logic [DataW-1:0] got);
    n_errors++;
    $display("[%0t] mismatch on %s after %0d results: expected 0x%08h, got 0x%08h",
             $realtime, what, n_checked, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    lookup_result_t          want;
    logic signed [DataW-1:0] got_value;
    logic                    got_status;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_value  = m_axis_tdata_o[DataW-1:0];
      got_status = m_axis_tdata_o[DataW];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got_value);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got_value !== want.value) report_mismatch("result_value", want.value, got_value);
        if (got_status !== want.status) report_mismatch("status", want.status, got_status);
      end
    end
  end

  // Ends a hung run: counts cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic run_table_phase(input int unsigned n, input int unsigned count);
    drain_results();
    write_entries_in_use(n);
    fill_table(n);
    repeat (count) send_random_item();
    drain_results();
  endtask

  // Empty and one-entry tables, range edges, breakpoints, midpoint with a
  // negative odd sum, full-scale slopes and a non-monotonic table.
  task automatic test_directed_cases();
    send_idle_pct = 10;
    recv_idle_pct = 46;
    // entry 0 and the top index written first, so nothing unloaded is read
    send_item(FuncLoad, IdxW'(0), 32'sh0001_0000, 32'sh0002_0000, 1'b0);
    send_item(FuncLoad, IdxW'(TableDepth - 1), QMaxW, QMinW, 1'b1);
    drain_results();
    write_entries_in_use(0);
    send_item(FuncQuery, IdxW'(0), 32'sh0000_0000, 32'sh0000_0000, 1'b1);
    drain_results();
    write_entries_in_use(1);
    send_item(FuncQuery, IdxW'(0), 32'sh0000_8000, 32'sh0000_0000, 1'b0);
    drain_results();
    write_entries_in_use(4);
    send_item(FuncLoad, IdxW'(0), QMinW,         QMaxW,         1'b0);
    send_item(FuncLoad, IdxW'(1), -32'sh0005_0000, QMinW,       1'b1);
    send_item(FuncLoad, IdxW'(2), 32'sh000A_0000, 32'sh0001_2345, 1'b0);
    send_item(FuncLoad, IdxW'(3), QMaxW,         -32'sd7,       1'b1);
    // at or beyond the outer breakpoints
    send_item(FuncQuery, IdxW'(0), QMinW, 32'sh0, 1'b1);
    send_item(FuncQuery, IdxW'(0), QMaxW, 32'sh0, 1'b0);
    // first point inside, full-scale negative slope
    send_item(FuncQuery, IdxW'(0), QMinW + 1, 32'sh0, 1'b1);
    // exactly on an inner breakpoint
    send_item(FuncQuery, IdxW'(0), -32'sh0005_0000, 32'sh0, 1'b1);
    // step mode at, just above and just below the midpoint
    send_item(FuncQuery, IdxW'(0), 32'sh0002_8000, 32'sh0, 1'b0);
    send_item(FuncQuery, IdxW'(0), 32'sh0002_8001, 32'sh0, 1'b0);
    send_item(FuncQuery, IdxW'(0), 32'sh0002_7FFF, 32'sh0, 1'b0);
    send_item(FuncQuery, IdxW'(0), 32'sh0000_0000, 32'sh0, 1'b1);
    send_item(FuncQuery, IdxW'(0), QMaxW - 1, 32'sh0, 1'b1);
    // entry 2 moved below entry 1: table no longer increasing
    send_item(FuncLoad, IdxW'(2), -32'sh0010_0000, QMaxW, 1'b0);
    send_item(FuncQuery, IdxW'(0), 32'sh0000_0000, 32'sh0, 1'b1);
    send_item(FuncQuery, IdxW'(0), -32'sh0006_0000, 32'sh0, 1'b0);
    drain_results();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 10;
    recv_idle_pct = 46;
    run_table_phase(2, 100);
    run_table_phase(7, 120);
    run_table_phase(TableDepth, 40);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 46;
    recv_idle_pct = 10;
    run_table_phase(16, 180);
    run_table_phase(3, 80);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_table_phase(32, 160);
    run_table_phase(5, 80);
  endtask

  // Receiver stops for a long stretch while items keep coming, so the
  // output register stays full and the input stream backs up.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    hold_request++;
    repeat (16) send_random_item();
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_receiver_stalls();
    test_sender_gaps();
    test_full_rate();
    test_output_backpressure();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d loads and %0d lookups (%0d out of range, %0d exact midpoints)",
             n_loads, n_queries, n_range, n_midpoints);
    $display("on tables of 0 to %0d entries; %0d results checked, %0d mismatches.",
             max_entries, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
